// ===== hdl/pam_pkg.sv =====
// Shared types, constants and helpers for the patch average glyph mapper.
`default_nettype none
package pam_pkg;

   localparam int MAX_COLUMNS    = 128;
   localparam int MAX_PATCH_SIDE = 64;
   localparam int MAX_FRAME_SIDE = 4096;

   localparam int COL_W      = $clog2(MAX_COLUMNS);
   localparam int SUM_W      = 22;
   localparam int PIX_SUM_W  = 10;
   localparam int LEVEL_W    = 4;
   localparam int GLYPH_W    = 7;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;

   localparam int FRAME_W = 13;
   localparam int PATCH_W = 7;
   localparam int GCOL_W  = 8;
   localparam int GROW_W  = 13;

   localparam logic [LEVEL_W-1:0] RAMP_TOP = 4'd9;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PATCH_WIDTH   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PATCH_HEIGHT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_GLYPH_COLUMNS = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_GLYPH_ROWS    = 3'd5;

   typedef struct packed {
      logic [COL_W-1:0] col;
      logic             first;
      logic             complete;
      logic             in_grid;
      logic             line_end;
      logic             frame_end;
   } pam_tile_type;

   function automatic logic [FRAME_W-1:0] clamp_frame(input logic [FRAME_W-1:0] v);
      logic [FRAME_W-1:0] r;
      r = v;
      if (v == '0) r = FRAME_W'(1);
      else if (v > FRAME_W'(MAX_FRAME_SIDE)) r = FRAME_W'(MAX_FRAME_SIDE);
      return r;
   endfunction

   function automatic logic [PATCH_W-1:0] clamp_patch(input logic [PATCH_W-1:0] v);
      logic [PATCH_W-1:0] r;
      r = v;
      if (v == '0) r = PATCH_W'(1);
      else if (v > PATCH_W'(MAX_PATCH_SIDE)) r = PATCH_W'(MAX_PATCH_SIDE);
      return r;
   endfunction

   function automatic logic [GCOL_W-1:0] clamp_gcol(input logic [GCOL_W-1:0] v);
      logic [GCOL_W-1:0] r;
      r = v;
      if (v == '0) r = GCOL_W'(1);
      else if (v > GCOL_W'(MAX_COLUMNS)) r = GCOL_W'(MAX_COLUMNS);
      return r;
   endfunction

   function automatic logic [GLYPH_W-1:0] ramp_glyph(input logic [LEVEL_W-1:0] lv);
      logic [GLYPH_W-1:0] g;
      case (lv)
         4'd0:    g = 7'd64;  // @
         4'd1:    g = 7'd37;  // %
         4'd2:    g = 7'd35;  // #
         4'd3:    g = 7'd42;  // *
         4'd4:    g = 7'd43;  // +
         4'd5:    g = 7'd61;  // =
         4'd6:    g = 7'd45;  // -
         4'd7:    g = 7'd58;  // :
         4'd8:    g = 7'd46;  // .
         default: g = 7'd32;  // space
      endcase
      return g;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/pam_sum_ram.sv =====
// Column sum memory: one write port, one registered read port.
`default_nettype none
module pam_sum_ram
   import pam_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             rd_en,
   input  wire logic [COL_W-1:0] rd_addr,
   output logic      [SUM_W-1:0] rd_data_ff,
   input  wire logic             wr_en,
   input  wire logic [COL_W-1:0] wr_addr,
   input  wire logic [SUM_W-1:0] wr_data
);

   logic [SUM_W-1:0] mem [MAX_COLUMNS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== hdl/pam_raster.sv =====
// Raster position and patch counters, one advance per accepted pixel.
`default_nettype none
module pam_raster
   import pam_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire logic               sof,
   input  wire logic [FRAME_W-1:0] fw,
   input  wire logic [FRAME_W-1:0] fh,
   input  wire logic [PATCH_W-1:0] pw,
   input  wire logic [PATCH_W-1:0] ph,
   input  wire logic [GCOL_W-1:0]  gc,
   input  wire logic [GROW_W-1:0]  gr,
   output pam_tile_type            tile
);

   logic [FRAME_W-2:0] pixel_x_ff, pixel_x_in, cur_x;
   logic [FRAME_W-2:0] pixel_y_ff, pixel_y_in, cur_y;
   logic [PATCH_W-2:0] ox_ff, ox_in, cur_ox;
   logic [PATCH_W-2:0] oy_ff, oy_in, cur_oy;
   logic [GCOL_W-1:0]  pc_ff, pc_in, cur_pc;
   logic [GROW_W-1:0]  pr_ff, pr_in, cur_pr;
   logic               in_grid, done_x, done_y, last_col;

   always_comb begin
      cur_x  = sof ? '0 : pixel_x_ff;
      cur_y  = sof ? '0 : pixel_y_ff;
      cur_ox = sof ? '0 : ox_ff;
      cur_oy = sof ? '0 : oy_ff;
      cur_pc = sof ? '0 : pc_ff;
      cur_pr = sof ? '0 : pr_ff;

      in_grid  = (cur_pc < gc) && (cur_pr < gr);
      done_x   = ({1'b0, cur_ox} + PATCH_W'(1)) >= pw;
      done_y   = ({1'b0, cur_oy} + PATCH_W'(1)) >= ph;
      last_col = ({1'b0, cur_pc} + (GCOL_W+1)'(1)) >= {1'b0, gc};

      tile.col       = cur_pc[COL_W-1:0];
      tile.first     = (cur_ox == '0) && (cur_oy == '0);
      tile.in_grid   = in_grid;
      tile.complete  = in_grid && done_x && done_y;
      tile.line_end  = last_col;
      tile.frame_end = last_col && (({1'b0, cur_pr} + (GROW_W+1)'(1)) >= {1'b0, gr});

      pixel_x_in = cur_x;
      pixel_y_in = cur_y;
      ox_in      = cur_ox;
      oy_in      = cur_oy;
      pc_in      = cur_pc;
      pr_in      = cur_pr;

      if (in_grid) begin
         if (done_x) begin
            ox_in = '0;
            pc_in = cur_pc + GCOL_W'(1);
         end else begin
            ox_in = cur_ox + (PATCH_W-1)'(1);
         end
      end

      if (({1'b0, cur_x} + FRAME_W'(1)) >= fw) begin
         pixel_x_in = '0;
         ox_in      = '0;
         pc_in      = '0;
         if (({1'b0, cur_y} + FRAME_W'(1)) >= fh) begin
            // frame wraps: restart everything
            pixel_y_in = '0;
            oy_in      = '0;
            pr_in      = '0;
         end else begin
            pixel_y_in = cur_y + (FRAME_W-1)'(1);
            if (done_y) begin
               oy_in = '0;
               if (cur_pr < gr) pr_in = cur_pr + GROW_W'(1);
            end else begin
               oy_in = cur_oy + (PATCH_W-1)'(1);
            end
         end
      end else begin
         pixel_x_in = cur_x + (FRAME_W-1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_x_ff <= '0;
         pixel_y_ff <= '0;
         ox_ff      <= '0;
         oy_ff      <= '0;
         pc_ff      <= '0;
         pr_ff      <= '0;
      end else if (advance) begin
         pixel_x_ff <= pixel_x_in;
         pixel_y_ff <= pixel_y_in;
         ox_ff      <= ox_in;
         oy_ff      <= oy_in;
         pc_ff      <= pc_in;
         pr_ff      <= pr_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/pam_level_div.sv =====
// Iterative ramp level search: one threshold compare per cycle.
`default_nettype none
module pam_level_div
   import pam_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [PATCH_W-1:0] pw,
   input  wire logic [PATCH_W-1:0] ph,
   input  wire logic               start,
   input  wire logic [SUM_W-1:0]   sum,
   output logic                    done_ff,
   output logic      [LEVEL_W-1:0] level_ff
);

   localparam int AREA_W   = 13;
   localparam int SCALED_W = SUM_W + 5;
   localparam logic [9:0] DEN_SCALE = 10'd765;

   typedef enum logic {LV_IDLE, LV_RUN} lv_state_type;

   lv_state_type        state_ff;
   logic [AREA_W-1:0]   area_ff;
   logic [SUM_W-1:0]    den_ff;
   logic [SCALED_W-1:0] scaled_ff;
   logic [SCALED_W-1:0] acc_ff;
   logic [SCALED_W-1:0] thr;
   logic [2*PATCH_W-1:0] area_prod;
   logic [AREA_W+9:0]   den_prod;

   assign area_prod = pw * ph;
   assign den_prod  = area_ff * DEN_SCALE;
   // level rises past k while 18*sum >= den*(2k+1)
   assign thr       = acc_ff + SCALED_W'(den_ff);

   // area/den follow configuration; user changes it only while idle, unchecked
   always_ff @(posedge clock) begin
      area_ff <= area_prod[AREA_W-1:0];
      den_ff  <= den_prod[SUM_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LV_IDLE;
         done_ff  <= 1'b0;
         level_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            LV_IDLE: begin
               if (start) begin
                  scaled_ff <= {1'b0, sum, 4'b0} + {4'b0, sum, 1'b0};
                  acc_ff    <= '0;
                  level_ff  <= '0;
                  state_ff  <= LV_RUN;
               end
            end
            LV_RUN: begin
               if (scaled_ff >= thr && level_ff != RAMP_TOP) begin
                  level_ff <= level_ff + LEVEL_W'(1);
                  acc_ff   <= acc_ff + SCALED_W'({den_ff, 1'b0});
               end else begin
                  done_ff  <= 1'b1;
                  state_ff <= LV_IDLE;
               end
            end
            default: state_ff <= LV_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

// ===== hdl/patch_average_ascii_mapper.sv =====
// Top level: pixel intake, column sum update and glyph output register.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_stall  channel_0..2, start_of_frame
//   rsp_      out        rsp_valid / rsp_stall  glyph, level, line_end, frame_end
//   csr_      in         csr_write_en           csr_index, csr_wdata
//
// A pixel that completes no patch is accepted, then, if it lies in the grid,
// its column sum gets a read-modify-write through the registered memory. A
// patch-completing pixel then runs the level search, one ramp threshold per
// cycle, and the hold state. Reset is synchronous and clears counters and
// control; column sums need no clearing. The output register frees intake
// from rsp_stall except when a second glyph is ready before the first is taken.
`default_nettype none
module patch_average_ascii_mapper
   import pam_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [7:0]            req_channel_0,
   input  wire logic [7:0]            req_channel_1,
   input  wire logic [7:0]            req_channel_2,
   input  wire logic                  req_start_of_frame,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic      [GLYPH_W-1:0]    rsp_glyph,
   output logic      [LEVEL_W-1:0]    rsp_level,
   output logic                       rsp_line_end,
   output logic                       rsp_frame_end,
   input  wire logic                  csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [1:0] {ST_IDLE, ST_ACC, ST_DIV, ST_HOLD} state_type;

   state_type          state_ff;
   logic [FRAME_W-1:0] frame_width_ff, frame_height_ff;
   logic [PATCH_W-1:0] patch_width_ff, patch_height_ff;
   logic [GCOL_W-1:0]  glyph_columns_ff;
   logic [GROW_W-1:0]  glyph_rows_ff;

   logic [FRAME_W-1:0] fw_c, fh_c;
   logic [PATCH_W-1:0] pw_c, ph_c;
   logic [GCOL_W-1:0]  gc_c;
   logic [GROW_W-1:0]  gr_c;

   logic               accept;
   logic               out_free;
   pam_tile_type       tile, tile_ff;
   logic [PIX_SUM_W-1:0] px_ff, px_in;
   logic [SUM_W-1:0]   rd_data;
   logic [SUM_W-1:0]   sum_in;
   logic               wr_en;
   logic               div_start;
   logic               div_done;
   logic [LEVEL_W-1:0] div_level;

   logic               rsp_valid_ff;
   logic [GLYPH_W-1:0] rsp_glyph_ff;
   logic [LEVEL_W-1:0] rsp_level_ff;
   logic               rsp_line_end_ff, rsp_frame_end_ff;

   assign fw_c = clamp_frame(frame_width_ff);
   assign fh_c = clamp_frame(frame_height_ff);
   assign pw_c = clamp_patch(patch_width_ff);
   assign ph_c = clamp_patch(patch_height_ff);
   assign gc_c = clamp_gcol(glyph_columns_ff);
   assign gr_c = clamp_frame(glyph_rows_ff);

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign px_in     = PIX_SUM_W'(req_channel_0) + PIX_SUM_W'(req_channel_1)
                    + PIX_SUM_W'(req_channel_2);

   // first pixel of a patch restarts the column sum
   assign sum_in    = tile_ff.first ? SUM_W'(px_ff) : rd_data + SUM_W'(px_ff);
   assign wr_en     = (state_ff == ST_ACC) && tile_ff.in_grid;
   assign div_start = (state_ff == ST_ACC) && tile_ff.complete;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_glyph     = rsp_glyph_ff;
   assign rsp_level     = rsp_level_ff;
   assign rsp_line_end  = rsp_line_end_ff;
   assign rsp_frame_end = rsp_frame_end_ff;

   pam_raster u_raster (
      .clock   (clock),
      .reset   (reset),
      .advance (accept),
      .sof     (req_start_of_frame),
      .fw      (fw_c),
      .fh      (fh_c),
      .pw      (pw_c),
      .ph      (ph_c),
      .gc      (gc_c),
      .gr      (gr_c),
      .tile    (tile)
   );

   pam_sum_ram u_sum_ram (
      .clock      (clock),
      .rd_en      (accept),
      .rd_addr    (tile.col),
      .rd_data_ff (rd_data),
      .wr_en      (wr_en),
      .wr_addr    (tile_ff.col),
      .wr_data    (sum_in)
   );

   pam_level_div u_level_div (
      .clock    (clock),
      .reset    (reset),
      .pw       (pw_c),
      .ph       (ph_c),
      .start    (div_start),
      .sum      (sum_in),
      .done_ff  (div_done),
      .level_ff (div_level)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff   <= FRAME_W'(640);
         frame_height_ff  <= FRAME_W'(480);
         patch_width_ff   <= PATCH_W'(8);
         patch_height_ff  <= PATCH_W'(13);
         glyph_columns_ff <= GCOL_W'(80);
         glyph_rows_ff    <= GROW_W'(36);
      end else if (csr_write_en) begin
         case (csr_index)
            REG_FRAME_WIDTH:   frame_width_ff   <= csr_wdata;
            REG_FRAME_HEIGHT:  frame_height_ff  <= csr_wdata;
            REG_PATCH_WIDTH:   patch_width_ff   <= csr_wdata[PATCH_W-1:0];
            REG_PATCH_HEIGHT:  patch_height_ff  <= csr_wdata[PATCH_W-1:0];
            REG_GLYPH_COLUMNS: glyph_columns_ff <= csr_wdata[GCOL_W-1:0];
            REG_GLYPH_ROWS:    glyph_rows_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         tile_ff <= tile;
         px_ff   <= px_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_HOLD) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept) state_ff <= ST_ACC;
            end
            ST_ACC: begin
               state_ff <= tile_ff.complete ? ST_DIV : ST_IDLE;
            end
            ST_DIV: begin
               if (div_done) state_ff <= ST_HOLD;
            end
            ST_HOLD: begin
               // hold until the output register can take the glyph
               if (out_free) begin
                  rsp_valid_ff     <= 1'b1;
                  rsp_glyph_ff     <= ramp_glyph(div_level);
                  rsp_level_ff     <= div_level;
                  rsp_line_end_ff  <= tile_ff.line_end;
                  rsp_frame_end_ff <= tile_ff.frame_end;
                  state_ff         <= ST_IDLE;
               end else if (rsp_valid_ff && !rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire
